/* rtl/core/double_error_correcting_byte_codec_core_macros.svh */
// assertion macros for the codec checker
`ifndef DOUBLE_ERROR_CORRECTING_BYTE_CODEC_CORE_MACROS_SVH
`define DOUBLE_ERROR_CORRECTING_BYTE_CODEC_CORE_MACROS_SVH

// property checked only out of reset
`define DECBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define DECBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/decbc_pkg.sv */
// shared constants, types and functions of the byte codec
package decbc_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned NUM_COLS = 16;

    // generator rows: upper byte selects data bits, lower byte is the identity
    localparam logic [WORD_W-1:0] GEN_ROWS [DATA_W] = '{
        16'hF080, 16'hCC40, 16'hAA20, 16'h5610,
        16'hE908, 16'h9504, 16'h7B02, 16'hE701
    };

    // parity check columns, data columns first, then check columns
    localparam logic [DATA_W-1:0] H_COLS [NUM_COLS] = '{
        8'hED, 8'hDB, 8'hAB, 8'h96, 8'h6A, 8'h55, 8'h33, 8'h0F,
        8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
    };

    // per data bit match flags, indexed by data bit position
    typedef struct packed {
        logic [DATA_W-1:0] single_hit;
        logic [DATA_W-1:0] pair_hit;
    } decbc_flags_t;

    // syndrome bit (7-r) is the parity of the word masked by row r
    function automatic logic [DATA_W-1:0] calc_syndrome(input logic [WORD_W-1:0] word);
        logic [DATA_W-1:0] syn;
        syn = '0;
        for (int r = 0; r < DATA_W; r++)
        begin
            syn[DATA_W-1-r] = ^(word & GEN_ROWS[r]);
        end
        return syn;
    endfunction

endpackage

/* rtl/core/decbc_syndrome.sv */
// input capture stage and syndrome stage
module decbc_syndrome (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic [7:0] check_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] out_data,
    output logic [7:0] out_syn
);
    import decbc_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg, s1_kind_next;
    logic [DATA_W-1:0] s1_data_reg, s1_data_next;
    logic [DATA_W-1:0] s1_check_reg, s1_check_next;
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_kind_reg, s2_kind_next;
    logic [DATA_W-1:0] s2_data_reg, s2_data_next;
    logic [DATA_W-1:0] s2_syn_reg, s2_syn_next;
    logic              s1_adv;
    logic              s2_adv;

    // stage advance, a stage moves when empty or when the next one moves
    assign s2_adv   = !s2_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    // capture stage, encoding is a syndrome with a zero check half
    always_comb
    begin
        s1_valid_next = s1_adv ? in_valid : s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        s1_data_next  = s1_data_reg;
        s1_check_next = s1_check_reg;
        if (s1_adv && in_valid)
        begin
            s1_kind_next  = kind;
            s1_data_next  = data_byte;
            s1_check_next = check_byte & {DATA_W{kind}};
        end
    end

    // syndrome stage
    always_comb
    begin
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
        s2_kind_next  = s2_kind_reg;
        s2_data_next  = s2_data_reg;
        s2_syn_next   = s2_syn_reg;
        if (s2_adv && s1_valid_reg)
        begin
            s2_kind_next = s1_kind_reg;
            s2_data_next = s1_data_reg;
            s2_syn_next  = calc_syndrome({s1_data_reg, s1_check_reg});
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= s1_kind_next;
        s1_data_reg  <= s1_data_next;
        s1_check_reg <= s1_check_next;
        s2_kind_reg  <= s2_kind_next;
        s2_data_reg  <= s2_data_next;
        s2_syn_reg   <= s2_syn_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_kind  = s2_kind_reg;
    assign out_data  = s2_data_reg;
    assign out_syn   = s2_syn_reg;

endmodule

/* rtl/core/decbc_locate.sv */
// error locator stage: single column and column pair matches
module decbc_locate (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    in_kind,
    input  logic [7:0]              in_data,
    input  logic [7:0]              in_syn,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_data,
    output logic [7:0]              out_syn,
    output decbc_pkg::decbc_flags_t out_flags
);
    import decbc_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [DATA_W-1:0] syn_reg, syn_next;
    decbc_flags_t      flags_reg, flags_next;
    decbc_flags_t      flags_calc;
    logic              adv;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    // column matches; columns are distinct, so a pair partner exists at most once
    always_comb
    begin
        flags_calc = '0;
        for (int k = 0; k < DATA_W; k++)
        begin
            flags_calc.single_hit[DATA_W-1-k] = (in_syn == H_COLS[k]);
            for (int j = 0; j < NUM_COLS; j++)
            begin
                if ((in_syn != '0) && ((in_syn ^ H_COLS[k]) == H_COLS[j]))
                begin
                    flags_calc.pair_hit[DATA_W-1-k] = 1'b1;
                end
            end
        end
    end

    // stage load, an encode transaction repairs nothing
    always_comb
    begin
        valid_next = adv ? in_valid : valid_reg;
        data_next  = data_reg;
        syn_next   = syn_reg;
        flags_next = flags_reg;
        if (adv && in_valid)
        begin
            data_next  = in_data;
            syn_next   = in_syn;
            flags_next = in_kind ? flags_calc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        syn_reg   <= syn_next;
        flags_reg <= flags_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_syn   = syn_reg;
    assign out_flags = flags_reg;

endmodule

/* rtl/core/decbc_correct.sv */
// correction stage and result register
module decbc_correct (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              in_data,
    input  logic [7:0]              in_syn,
    input  decbc_pkg::decbc_flags_t in_flags,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_data,
    output logic [7:0]              out_check
);
    import decbc_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [DATA_W-1:0] check_reg, check_next;
    logic [DATA_W-1:0] flip_mask;
    logic              adv;

    assign adv      = !valid_reg || !out_stall;
    assign in_stall = !adv;

    // a single data column match wins over the pair search
    assign flip_mask = (|in_flags.single_hit) ? in_flags.single_hit : in_flags.pair_hit;

    always_comb
    begin
        valid_next = adv ? in_valid : valid_reg;
        data_next  = data_reg;
        check_next = check_reg;
        if (adv && in_valid)
        begin
            data_next  = in_data ^ flip_mask;
            check_next = in_syn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        check_reg <= check_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_check = check_reg;

endmodule

/* rtl/core/double_error_correcting_byte_codec_core.sv */
// Systematic (16,8) double error correcting byte codec. kind 0 encodes
// data_byte and returns it with its check byte; kind 1 decodes the word
// {data_byte, check_byte}, returns the repaired data byte and the syndrome.
// The core is a four stage pipeline (capture, syndrome, error locate,
// correct) that takes one transaction per cycle while result_stall is
// low and passes each result through the stages in that order. Stall on the
// result side backs up stage by stage; empty stages keep filling, so
// item_stall rises only when all four stages hold data. No state is kept
// between transactions.
module double_error_correcting_byte_codec_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic [7:0] check_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_data,
    output logic [7:0] out_check
);
    import decbc_pkg::*;

    logic              syn_valid;
    logic              syn_stall;
    logic              syn_kind;
    logic [DATA_W-1:0] syn_data;
    logic [DATA_W-1:0] syn_value;
    logic              loc_valid;
    logic              loc_stall;
    logic [DATA_W-1:0] loc_data;
    logic [DATA_W-1:0] loc_syn;
    decbc_flags_t      loc_flags;

    // capture and syndrome stages
    decbc_syndrome u_syndrome (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item_valid),
        .in_stall   (item_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .check_byte (check_byte),
        .out_valid  (syn_valid),
        .out_stall  (syn_stall),
        .out_kind   (syn_kind),
        .out_data   (syn_data),
        .out_syn    (syn_value)
    );

    // error locator stage
    decbc_locate u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (syn_valid),
        .in_stall  (syn_stall),
        .in_kind   (syn_kind),
        .in_data   (syn_data),
        .in_syn    (syn_value),
        .out_valid (loc_valid),
        .out_stall (loc_stall),
        .out_data  (loc_data),
        .out_syn   (loc_syn),
        .out_flags (loc_flags)
    );

    // correction and result stage
    decbc_correct u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (loc_valid),
        .in_stall  (loc_stall),
        .in_data   (loc_data),
        .in_syn    (loc_syn),
        .in_flags  (loc_flags),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_data),
        .out_check (out_check)
    );

endmodule

/* rtl/core/decbc_checker.sv */
// port level checker for the byte codec and its bind
`include "double_error_correcting_byte_codec_core_macros.svh"

module decbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       kind,
    input logic [7:0] data_byte,
    input logic [7:0] check_byte,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_data,
    input logic [7:0] out_check
);
    logic [2:0] inflight_reg, inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = item_valid && !item_stall;
    assign out_acc = result_valid && !result_stall;

    // transactions accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `DECBC_ASSERT_ALWAYS(a_rst_no_result, !rst_n |-> !result_valid, "result valid in reset")
    `DECBC_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(out_data) && $stable(out_check), "stalled result changed")
    `DECBC_ASSERT(a_no_invented, result_valid |-> inflight_reg != 3'd0, "result without transaction")
    `DECBC_ASSERT(a_depth, inflight_reg <= 3'd4, "more transactions than stages")
    `DECBC_ASSERT(a_empty_ready, inflight_reg == 3'd0 |-> !item_stall, "stall with empty pipeline")

endmodule

bind double_error_correcting_byte_codec_core decbc_checker u_decbc_checker (.*);

/* tb/decbc_scoreboard_pkg.sv */
// scoreboard class and expected-result predictor for the byte codec testbench
package decbc_scoreboard_pkg;

    // transaction kinds on the item channel
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // one expected result transaction
    typedef struct {
        logic [7:0] data;
        logic [7:0] check;
    } codec_result_t;

    class codec_scoreboard;

        // generator rows, row 0 in the top 16 bits
        localparam logic [127:0] GEN_ROW_TABLE =
            128'hF080_CC40_AA20_5610_E908_9504_7B02_E701;

        codec_result_t expected_results[$];
        int unsigned   error_count;

        function new();
            error_count = 0;
        endfunction

        function logic [15:0] gen_row(int r);
            return GEN_ROW_TABLE[127-16*r -: 16];
        endfunction

        // column c of the check matrix: bit (15-c) of every row, row 0 on top
        function logic [7:0] h_column(int c);
            logic [7:0]  col;
            logic [15:0] row;
            for (int r = 0; r < 8; r++)
            begin
                row = gen_row(r);
                col[7-r] = row[15-c];
            end
            return col;
        endfunction

        // data bit toggled by a column; check columns toggle nothing
        function logic [7:0] column_data_mask(int c);
            if (c >= 8)
                return 8'h00;
            return 8'h01 << (7 - c);
        endfunction

        // check byte of a data byte
        function logic [7:0] check_bits(logic [7:0] d);
            logic [7:0]  chk;
            logic [15:0] row;
            for (int r = 0; r < 8; r++)
            begin
                row = gen_row(r);
                chk[7-r] = ^(d & row[15:8]);
            end
            return chk;
        endfunction

        // syndrome of a received word {data, check}
        function logic [7:0] syndrome_of(logic [7:0] d, logic [7:0] c);
            logic [7:0] syn;
            for (int r = 0; r < 8; r++)
                syn[7-r] = ^({d, c} & gen_row(r));
            return syn;
        endfunction

        // single data column first, else xor of every matching column pair
        function logic [7:0] repaired_data(logic [7:0] d, logic [7:0] syn);
            logic [7:0] fixed;
            fixed = d;
            for (int i = 0; i < 8; i++)
            begin
                if (syn == h_column(i))
                    return d ^ column_data_mask(i);
            end
            for (int i = 0; i < 16; i++)
            begin
                for (int j = i; j < 16; j++)
                begin
                    if ((h_column(i) ^ h_column(j)) == syn)
                    begin
                        fixed ^= column_data_mask(i);
                        if (i != j)
                            fixed ^= column_data_mask(j);
                    end
                end
            end
            return fixed;
        endfunction

        // accepted item: work out its result and queue it
        function void note_item(logic kind, logic [7:0] d, logic [7:0] c);
            codec_result_t res;
            if (kind == KIND_ENCODE)
            begin
                res.data  = d;
                res.check = check_bits(d);
            end
            else
            begin
                res.check = syndrome_of(d, c);
                res.data  = (res.check == 8'h00) ? d : repaired_data(d, res.check);
            end
            expected_results.push_back(res);
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(logic [7:0] od, logic [7:0] oc);
            codec_result_t res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: out_data %02h out_check %02h", od, oc);
                error_count++;
                return;
            end
            res = expected_results.pop_front();
            if (od !== res.data)
            begin
                $error("out_data mismatch: expected %02h, actual %02h", res.data, od);
                error_count++;
            end
            if (oc !== res.check)
            begin
                $error("out_check mismatch: expected %02h, actual %02h", res.check, oc);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

/* tb/double_error_correcting_byte_codec_core_test.sv */
// testbench top for the double error correcting byte codec core
module double_error_correcting_byte_codec_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import decbc_scoreboard_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // directed error patterns over {data, check} of a valid codeword
    localparam logic [15:0] DIRECTED_FLIPS [12] = '{
        16'h0000, 16'h8000, 16'h0100, 16'h0080, 16'h0001, 16'h2400,
        16'h1008, 16'h0042, 16'h0808, 16'h8001, 16'h1111, 16'hFFFF
    };

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] check_byte;
    logic       result_valid;
    logic       result_stall;
    logic [7:0] out_data;
    logic [7:0] out_check;

    codec_scoreboard sb;
    int unsigned     cycle_count;
    logic            sender_burst;
    logic            receiver_burst;

    double_error_correcting_byte_codec_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .check_byte   (check_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_data     (out_data),
        .out_check    (out_check)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [15:0] codeword(logic [7:0] d);
        return {d, sb.check_bits(d)};
    endfunction

    // send one item after a random gap, wait for its acceptance
    task automatic drive_item(logic k, logic [7:0] d, logic [7:0] c);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0)
            sender_burst = ~sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        data_byte  <= d;
        check_byte <= c;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        sb.note_item(k, d, c);
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    // stimulus
    initial
    begin
        logic [15:0] word;
        logic [15:0] flips;
        int unsigned sel;
        int unsigned nflips;
        int unsigned p1;
        int unsigned p2;

        sb             = new();
        sender_burst   = 1'b0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        kind         <= KIND_ENCODE;
        data_byte    <= 8'h00;
        check_byte   <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: encode extremes, check byte ignored on encode
        drive_item(KIND_ENCODE, 8'h00, 8'hFF);
        drive_item(KIND_ENCODE, 8'hFF, 8'h00);
        drive_item(KIND_ENCODE, 8'h01, 8'hA5);
        drive_item(KIND_ENCODE, 8'h80, 8'h5A);
        drive_item(KIND_ENCODE, 8'h5A, 8'h00);

        // directed: clean word, single and double errors, uncorrectable
        for (int i = 0; i < 12; i++)
        begin
            word = codeword(8'hC6 ^ 8'(i * 37)) ^ DIRECTED_FLIPS[i];
            drive_item(KIND_DECODE, word[15:8], word[7:0]);
        end
        drive_item(KIND_DECODE, 8'h00, 8'h00);
        drive_item(KIND_DECODE, 8'hFF, 8'hFF);
        drive_item(KIND_DECODE, 8'h00, 8'hFF);
        drive_item(KIND_DECODE, 8'hFF, 8'h00);
        wait_drained();

        // random: mostly codewords with up to two flipped bits
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 450 == 449)
                wait_drained();
            sel = $urandom_range(0, 9);
            if (sel < 3)
            begin
                drive_item(KIND_ENCODE, 8'($urandom), 8'($urandom));
            end
            else if (sel == 3)
            begin
                drive_item(KIND_DECODE, 8'($urandom), 8'($urandom));
            end
            else
            begin
                flips  = 16'h0000;
                nflips = $urandom_range(0, 2);
                p1     = $urandom_range(0, 15);
                p2     = (p1 + $urandom_range(1, 15)) % 16;
                if (nflips >= 1)
                    flips[p1] = 1'b1;
                if (nflips == 2)
                    flips[p2] = 1'b1;
                word = codeword(8'($urandom)) ^ flips;
                drive_item(KIND_DECODE, word[15:8], word[7:0]);
            end
        end

        // drain and finish
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stall before each transaction, then accept and check
    initial
    begin
        int unsigned hold;

        receiver_burst = 1'b0;
        result_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_burst = ~receiver_burst;
            hold = receiver_burst ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            sb.check_result(out_data, out_check);
        end
    end

endmodule
